[src/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants and the arctangent table for the haversine distance pipe.
// ----------------------------------------------------------------------------
package hvd_pkg;

    // Half-angle path: a sum or difference of two coordinates, 2^-17 degree
    localparam int ANG_W = 26;
    localparam int RED_W = 24;
    localparam logic [ANG_W-1:0] FULL_TURN    = 26'd47185920;
    localparam logic [ANG_W-1:0] HALF_TURN    = 26'd23592960;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 26'd11796480;

    // Degrees to Q30 radians, round(pi/180 * 2^45), split into two halves
    localparam logic [63:0] DEG_TO_RAD = 64'd614083138197;
    localparam logic [19:0] D2R_LO = DEG_TO_RAD[19:0];
    localparam logic [19:0] D2R_HI = DEG_TO_RAD[39:20];

    // Q1.30 fractions
    localparam int Q_W = 31;
    localparam logic [Q_W-1:0] Q_ONE = 31'h4000_0000;
    localparam logic [63:0] Q_HALF = 64'd536870912;

    localparam int CW = 33;
    localparam logic signed [CW-1:0] CORDIC_INV = 33'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q  = 33'sd1686629713;
    localparam logic [31:0] PI_Q = 32'd3373259426;

    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_W = 31;
    localparam int RAD_W = 61;

    localparam int R_W = 23;
    localparam logic [R_W-1:0] RADIUS_RST = 23'd6371000;
    localparam int DIST_W = 25;
    localparam logic [DIST_W-1:0] MAX_DIST =
        25'(((64'd8388607 * 64'd3373259426) + 64'd536870912) >> 30);

    localparam int SIN_LAT  = 4 + CORDIC_STEPS + 3;
    localparam int SQRT_LAT = ROOT_W;
    localparam int PIPE_LAT = 1 + SIN_LAT + 3 + SQRT_LAT + 2 + SQRT_LAT + CORDIC_STEPS + 3;

    // atan(2^-i) in Q30
    function automatic logic [31:0] f_atan(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            24: v = 32'd64;
            25: v = 32'd32;
            26: v = 32'd16;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[src/hvd_sine.sv]
// ----------------------------------------------------------------------------
// hvd_sine
// Squared sine of a half angle: reduce, fold, scale to radians, CORDIC, square.
// ----------------------------------------------------------------------------
module hvd_sine import hvd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_ang,
    output logic [Q_W-1:0]          o_sq
);

    logic [ANG_W-1:0] r_red;
    logic [ANG_W-1:0] w_f1;
    logic [ANG_W-1:0] w_f2;
    logic [RED_W-1:0] r_fold;
    logic [43:0]      r_p_lo;
    logic [43:0]      r_p_hi;
    logic [63:0]      w_tsum;
    logic [Q_W-1:0]   r_theta;
    logic signed [CW-1:0] r_x [1:CORDIC_STEPS];
    logic signed [CW-1:0] r_y [1:CORDIC_STEPS];
    logic signed [CW-1:0] r_z [1:CORDIC_STEPS];
    logic signed [CW-1:0] w_yl;
    logic [Q_W-1:0]   r_yc;
    logic [61:0]      r_sq;
    logic [63:0]      w_rsum;
    logic [Q_W-1:0]   r_out;

    // Fold the angle into the first quadrant
    assign w_f1 = (r_red >= HALF_TURN) ? (FULL_TURN - r_red) : r_red;
    assign w_f2 = (w_f1 > QUARTER_TURN) ? (HALF_TURN - w_f1) : w_f1;
    assign w_tsum = {r_p_hi, 20'd0} + {20'd0, r_p_lo} + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= i_ang[ANG_W-1] ? ($unsigned(i_ang) + FULL_TURN) : $unsigned(i_ang);
            r_fold  <= w_f2[RED_W-1:0];
            r_p_lo  <= r_fold * D2R_LO;
            r_p_hi  <= r_fold * D2R_HI;
            r_theta <= w_tsum[62:32];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_rot
            logic signed [CW-1:0] w_x;
            logic signed [CW-1:0] w_y;
            logic signed [CW-1:0] w_z;
            logic signed [CW-1:0] w_at;
            if (gi == 0) begin : g_first
                assign w_x = CORDIC_INV;
                assign w_y = '0;
                assign w_z = $signed({2'b00, r_theta});
            end else begin : g_next
                assign w_x = r_x[gi];
                assign w_y = r_y[gi];
                assign w_z = r_z[gi];
            end
            assign w_at = $signed({1'b0, f_atan(gi)});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_z >= 0) begin
                        r_x[gi+1] <= w_x - (w_y >>> gi);
                        r_y[gi+1] <= w_y + (w_x >>> gi);
                        r_z[gi+1] <= w_z - w_at;
                    end else begin
                        r_x[gi+1] <= w_x + (w_y >>> gi);
                        r_y[gi+1] <= w_y - (w_x >>> gi);
                        r_z[gi+1] <= w_z + w_at;
                    end
                end
            end
        end
    endgenerate

    assign w_yl   = r_y[CORDIC_STEPS];
    assign w_rsum = {2'b00, r_sq} + Q_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_yl < 0) begin
                r_yc <= '0;
            end else if (w_yl > $signed({2'b00, Q_ONE})) begin
                r_yc <= Q_ONE;
            end else begin
                r_yc <= w_yl[Q_W-1:0];
            end
            r_sq  <= r_yc * r_yc;
            r_out <= w_rsum[60:30];
        end
    end

    // x and z of the last step are not needed
    logic w_unused;
    assign w_unused = ^{r_x[CORDIC_STEPS], r_z[CORDIC_STEPS]};

    assign o_sq = r_out;

endmodule

[src/hvd_isqrt.sv]
// ----------------------------------------------------------------------------
// hvd_isqrt
// Floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module hvd_isqrt import hvd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_val,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0] r_root [1:ROOT_W];

    genvar gk;
    generate
        for (gk = 0; gk < ROOT_W; gk++) begin : g_bit
            localparam int B = ROOT_W - 1 - gk;
            logic [RAD_W-1:0]  w_rem;
            logic [ROOT_W-1:0] w_root;
            logic [62:0]       w_test;
            if (gk == 0) begin : g_first
                assign w_rem  = i_val;
                assign w_root = '0;
            end else begin : g_next
                assign w_rem  = r_rem[gk];
                assign w_root = r_root[gk];
            end
            // (root + 2^B)^2 - root^2
            assign w_test = ({32'd0, w_root} << (B + 1)) + (63'd1 << (2 * B));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if ({2'b00, w_rem} >= w_test) begin
                        r_rem[gk+1]  <= w_rem - w_test[RAD_W-1:0];
                        r_root[gk+1] <= w_root | (ROOT_W'(1) << B);
                    end else begin
                        r_rem[gk+1]  <= w_rem;
                        r_root[gk+1] <= w_root;
                    end
                end
            end
        end
    endgenerate

    logic w_unused;
    assign w_unused = ^r_rem[ROOT_W];

    assign o_root = r_root[ROOT_W];

endmodule

[src/haversine_distance.sv]
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance in metres between two points, haversine formula.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one item: lat_a, lon_a, lat_b, lon_b in units of
//   2^-16 degree. It is taken when i_in_valid is high and o_in_stall is low.
//   Output channel carries o_distance_m, taken when o_out_valid is high and
//   i_out_stall is low.
//   One item enters every cycle while the receiver does not stall. The pipe
//   holds one 30-step CORDIC sine chain (the three sines run side by side),
//   then two 31-step square-root chains and the 30-step arcsine CORDIC
//   chain, each step a register stage.
//   The whole pipe advances together: while the output register holds an
//   item and the receiver stalls, every stage holds and o_in_stall is high.
//   Bubbles travel with their valid bit and never reach the output.
//   The radius register is written through i_cfg_valid/i_cfg_data (ready is
//   always high); write it only while the pipe is empty.
//   Synchronous reset clears all valid bits and loads the radius 6371000 m.
// ----------------------------------------------------------------------------
module haversine_distance import hvd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [23:0]      i_lat_a,
    input  logic signed [24:0]      i_lon_a,
    input  logic signed [23:0]      i_lat_b,
    input  logic signed [24:0]      i_lon_b,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [DIST_W-1:0]       o_distance_m,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [R_W-1:0]          i_cfg_data
);

    localparam int LAST = PIPE_LAT - 1;

    logic                 w_en;
    logic [PIPE_LAT-1:0]  r_vld;
    logic [R_W-1:0]       r_radius;

    // Stall when the output holds an item the receiver refuses
    assign w_en        = !(r_vld[LAST] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RADIUS_RST;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAST-1:0], i_in_valid};
            end
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    // Half angles: latitude difference, longitude difference, latitude sum
    logic signed [ANG_W-1:0] r_dlat;
    logic signed [ANG_W-1:0] r_dlon;
    logic signed [ANG_W-1:0] r_slat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dlat <= ANG_W'(i_lat_b) - ANG_W'(i_lat_a);
            r_dlon <= ANG_W'(i_lon_b) - ANG_W'(i_lon_a);
            r_slat <= ANG_W'(i_lat_b) + ANG_W'(i_lat_a);
        end
    end

    logic [Q_W-1:0] w_a2;
    logic [Q_W-1:0] w_b2;
    logic [Q_W-1:0] w_c2;

    hvd_sine u_sin_a (.i_clk(i_clk), .i_en(w_en), .i_ang(r_dlat), .o_sq(w_a2));
    hvd_sine u_sin_b (.i_clk(i_clk), .i_en(w_en), .i_ang(r_dlon), .o_sq(w_b2));
    hvd_sine u_sin_c (.i_clk(i_clk), .i_en(w_en), .i_ang(r_slat), .o_sq(w_c2));

    // h = a2 + b2 * clamp(1 - a2 - c2)
    logic signed [CW-1:0] w_inner;
    logic [Q_W-1:0]       r_inner;
    logic [Q_W-1:0]       r_a2d;
    logic [Q_W-1:0]       r_b2d;
    logic [61:0]          r_prod;
    logic [Q_W-1:0]       r_a2e;
    logic [63:0]          w_psum;
    logic [32:0]          w_h;
    logic [Q_W-1:0]       r_h;

    assign w_inner = $signed({2'b00, Q_ONE}) - $signed({2'b00, w_a2})
                   - $signed({2'b00, w_c2});
    assign w_psum  = {2'b00, r_prod} + Q_HALF;
    assign w_h     = {2'b00, r_a2e} + {1'b0, w_psum[61:30]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inner <= (w_inner < 0) ? '0 : w_inner[Q_W-1:0];
            r_a2d   <= w_a2;
            r_b2d   <= w_b2;
            r_prod  <= r_b2d * r_inner;
            r_a2e   <= r_a2d;
            r_h     <= (w_h > {2'b00, Q_ONE}) ? Q_ONE : w_h[Q_W-1:0];
        end
    end

    // s = sqrt(h), q = sqrt(1 - s^2)
    logic [ROOT_W-1:0] w_s;
    logic [ROOT_W-1:0] r_s1;
    logic [ROOT_W-1:0] r_s2;
    logic [61:0]       r_ssq;
    logic [RAD_W-1:0]  r_v2;
    logic [ROOT_W-1:0] w_q;
    logic [ROOT_W-1:0] r_sd [1:SQRT_LAT];

    hvd_isqrt u_sqrt_s (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_val ({r_h, 30'd0}),
        .o_root(w_s)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= w_s;
            r_ssq <= w_s * w_s;
            r_s2  <= r_s1;
            r_v2  <= (RAD_W'(1) << 60) - r_ssq[RAD_W-1:0];
            r_sd[1] <= r_s2;
            for (int k = 2; k <= SQRT_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    hvd_isqrt u_sqrt_q (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_val (r_v2),
        .o_root(w_q)
    );

    // asin(s) = atan2(s, q) by CORDIC vectoring
    logic signed [CW-1:0] r_vx [1:CORDIC_STEPS];
    logic signed [CW-1:0] r_vy [1:CORDIC_STEPS];
    logic signed [CW-1:0] r_vz [1:CORDIC_STEPS];
    logic                 r_vzero [1:CORDIC_STEPS];

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_vec
            logic signed [CW-1:0] w_x;
            logic signed [CW-1:0] w_y;
            logic signed [CW-1:0] w_z;
            logic                 w_zero;
            logic signed [CW-1:0] w_at;
            if (gi == 0) begin : g_first
                assign w_x    = $signed({2'b00, w_q});
                assign w_y    = $signed({2'b00, r_sd[SQRT_LAT]});
                assign w_z    = '0;
                assign w_zero = (r_sd[SQRT_LAT] == '0);
            end else begin : g_next
                assign w_x    = r_vx[gi];
                assign w_y    = r_vy[gi];
                assign w_z    = r_vz[gi];
                assign w_zero = r_vzero[gi];
            end
            assign w_at = $signed({1'b0, f_atan(gi)});
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_vzero[gi+1] <= w_zero;
                    if (w_y >= 0) begin
                        r_vx[gi+1] <= w_x + (w_y >>> gi);
                        r_vy[gi+1] <= w_y - (w_x >>> gi);
                        r_vz[gi+1] <= w_z + w_at;
                    end else begin
                        r_vx[gi+1] <= w_x - (w_y >>> gi);
                        r_vy[gi+1] <= w_y + (w_x >>> gi);
                        r_vz[gi+1] <= w_z - w_at;
                    end
                end
            end
        end
    endgenerate

    // Clamp the angle, scale by the diameter, limit to half the circumference
    logic signed [CW-1:0] w_zf;
    logic [Q_W-1:0]       r_ang;
    logic [54:0]          r_dmul;
    logic [54:0]          r_lmul;
    logic [55:0]          w_dsum;
    logic [55:0]          w_lsum;
    logic [DIST_W:0]      w_dist;
    logic [DIST_W:0]      w_lim;
    logic [DIST_W-1:0]    r_dist;

    assign w_zf   = r_vz[CORDIC_STEPS];
    assign w_dsum = {1'b0, r_dmul} + 56'(Q_HALF);
    assign w_lsum = {1'b0, r_lmul} + 56'(Q_HALF);
    assign w_dist = w_dsum[55:30];
    assign w_lim  = w_lsum[55:30];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_vzero[CORDIC_STEPS] || w_zf < 0) begin
                r_ang <= '0;
            end else if (w_zf > HALF_PI_Q) begin
                r_ang <= HALF_PI_Q[Q_W-1:0];
            end else begin
                r_ang <= w_zf[Q_W-1:0];
            end
            r_dmul <= {r_radius, 1'b0} * r_ang;
            r_lmul <= r_radius * PI_Q;
            r_dist <= (w_dist > w_lim) ? w_lim[DIST_W-1:0] : w_dist[DIST_W-1:0];
        end
    end

    logic w_unused;
    assign w_unused = ^{r_vx[CORDIC_STEPS], r_vy[CORDIC_STEPS]};

    assign o_out_valid  = r_vld[LAST];
    assign o_distance_m = r_dist;

    // A held output freezes the whole pipe
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output item");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_distance_m <= MAX_DIST))
        else $error("distance beyond half circumference");

endmodule

[sim/haversine_distance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_checker
// Watches both channels and the radius write port of the distance pipe,
// predicts each distance from the accepted point pair and compares in order.
// ----------------------------------------------------------------------------
module haversine_distance_checker import hvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [23:0] i_lat_a,
    input  logic signed [24:0] i_lon_a,
    input  logic signed [23:0] i_lat_b,
    input  logic signed [24:0] i_lon_b,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [DIST_W-1:0]  i_distance_m,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [R_W-1:0]     i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [R_W-1:0]    radius_m;
    logic [DIST_W-1:0] dist_q[$];

    assign o_pending = dist_q.size();

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res   = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // squared sine of a half angle in 2^-17 degree, Q30
    function automatic longint half_sine_sq(longint ang);
        longint turn, r, x, y, z, t;
        turn = 360 * 131072;
        r = ang % turn;
        x = 652032874;
        y = 0;
        if (r < 0) r += turn;
        if (r >= turn / 2) r = turn - r;
        if (r > turn / 4) r = turn / 2 - r;
        z = longint'((longint'(r) * 64'd614083138197 + 64'd2147483648) >> 32);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - floor_shift(y, i);
                y = y + floor_shift(t, i);
                z = z - longint'(f_atan(i));
            end else begin
                x = x + floor_shift(y, i);
                y = y - floor_shift(t, i);
                z = z + longint'(f_atan(i));
            end
        end
        if (y < 0) y = 0;
        if (y > (64'd1 << 30)) y = 64'd1 << 30;
        return (y * y + (64'd1 << 29)) >>> 30;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(longint la, longint loa,
                                                          longint lb, longint lob,
                                                          longint unsigned rad);
        longint a2, b2, c2, inner, h, x, y, z, t, one;
        longint unsigned s, q, dist_v, lim;
        one = 64'd1 << 30;
        a2 = half_sine_sq(lb - la);
        b2 = half_sine_sq(lob - loa);
        c2 = half_sine_sq(lb + la);
        inner = one - a2 - c2;
        z = 0;
        if (inner < 0) inner = 0;
        if (inner > one) inner = one;
        h = a2 + ((b2 * inner + (64'd1 << 29)) >>> 30);
        if (h > one) h = one;
        s = isqrt(longint'(h) << 30);
        if (s > one) s = one;
        q = isqrt((64'd1 << 60) - s * s);
        x = q;
        y = s;
        if (s != 0) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                t = x;
                if (y >= 0) begin
                    x = x + floor_shift(y, i);
                    y = y - floor_shift(t, i);
                    z = z + longint'(f_atan(i));
                end else begin
                    x = x - floor_shift(y, i);
                    y = y + floor_shift(t, i);
                    z = z - longint'(f_atan(i));
                end
            end
        end
        if (z < 0) z = 0;
        if (z > 1686629713) z = 1686629713;
        dist_v = (2 * rad * longint'(z) + (64'd1 << 29)) >> 30;
        lim    = (rad * 64'd3373259426 + (64'd1 << 29)) >> 30;
        if (dist_v > lim) dist_v = lim;
        return dist_v[DIST_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radius_m     <= RADIUS_RST;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) radius_m <= i_cfg_data;
            if (i_in_valid && !i_in_stall)
                dist_q.push_back(predict_distance(i_lat_a, i_lon_a, i_lat_b, i_lon_b,
                                                  radius_m));
            if (i_out_valid && !i_out_stall) begin
                if (dist_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected distance %0d", i_distance_m);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (dist_q[0] !== i_distance_m) begin
                        if (o_fail_count < 10)
                            $display("distance mismatch: expected %0d actual %0d",
                                     dist_q[0], i_distance_m);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(dist_q.pop_front());
                end
            end
        end
    end

endmodule

[sim/haversine_distance_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_tb
// Drives point pairs through the distance pipe under several idling phases
// and radius settings; the checker predicts and compares every distance.
// ----------------------------------------------------------------------------
module haversine_distance_tb;
    import hvd_pkg::*;

    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;
    localparam int WATCHDOG = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [23:0] lat_a = '0;
    logic signed [24:0] lon_a = '0;
    logic signed [23:0] lat_b = '0;
    logic signed [24:0] lon_b = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DIST_W-1:0]  distance_m;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [R_W-1:0]     cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    bit                 hold_off = 1'b0;
    int                 quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    haversine_distance i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_lat_a(lat_a), .i_lon_a(lon_a), .i_lat_b(lat_b), .i_lon_b(lon_b),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_distance_m(distance_m),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    haversine_distance_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_lat_a(lat_a), .i_lon_a(lon_a), .i_lat_b(lat_b), .i_lon_b(lon_b),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_distance_m(distance_m),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall at the phase rate, or hold for a long stretch on request.
    always @(posedge i_clk) begin
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Watchdog: count cycles with no handshake on either channel outside a hold-off.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one point pair; hold it until accepted and leave valid high, so that
    // finish_burst or an idle start of the next call drops it.
    task automatic send_pair(logic signed [23:0] la, logic signed [24:0] loa,
                             logic signed [23:0] lb, logic signed [24:0] lob);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        lat_a <= la;
        lon_a <= loa;
        lat_b <= lb;
        lon_b <= lob;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic finish_burst();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the pipe to drain, then write the radius.
    task automatic write_radius(logic [R_W-1:0] rad);
        finish_burst();
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rad;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-range points; now and then any value the ports allow.
    task automatic send_random();
        logic signed [23:0] la, lb;
        logic signed [24:0] loa, lob;
        if ($urandom_range(9) == 0) begin
            la  = 24'($urandom);
            lb  = 24'($urandom);
            loa = 25'($urandom);
            lob = 25'($urandom);
        end else begin
            la  = 24'($signed($urandom_range(2 * LAT_MAX)) - LAT_MAX);
            loa = 25'($signed($urandom_range(2 * LON_MAX)) - LON_MAX);
            if ($urandom_range(3) == 0) begin
                // nearby second point
                lb  = 24'(la + $signed($urandom_range(2000)) - 1000);
                lob = 25'(loa + $signed($urandom_range(2000)) - 1000);
            end else begin
                lb  = 24'($signed($urandom_range(2 * LAT_MAX)) - LAT_MAX);
                lob = 25'($signed($urandom_range(2 * LON_MAX)) - LON_MAX);
            end
        end
        send_pair(la, loa, lb, lob);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, same point, poles, antipodes, wrap-around.
        send_pair('0, '0, '0, '0);
        send_pair(24'(LAT_MAX), '0, 24'(-LAT_MAX), '0);
        send_pair('0, '0, '0, 25'(LON_MAX));
        send_pair('0, 25'(-LON_MAX), '0, 25'(LON_MAX));
        send_pair(24'(LAT_MAX), 25'sd123, 24'(LAT_MAX), -25'sd4567);
        send_pair(24'(-LAT_MAX), 25'(LON_MAX), 24'(-LAT_MAX), 25'(-LON_MAX));
        send_pair(24'sd100, 25'sd100, 24'sd101, 25'sd100);
        send_pair('0, '0, 24'sd1, 25'sd1);
        send_pair(24'sd3000000, 25'sd5000000, -24'sd3000000, -25'sd6796480);
        send_pair(24'h7fffff, 25'h0ffffff, 24'h800000, 25'h1000000);
        send_pair(24'h800000, 25'h1000000, 24'h7fffff, 25'h0ffffff);
        send_pair(24'hffffff, 25'h1ffffff, '0, '0);
        send_pair(24'(LAT_MAX), 25'(LON_MAX), 24'(LAT_MAX), 25'(LON_MAX));
        send_pair(24'sd2949120, '0, -24'sd2949120, 25'(LON_MAX));
        write_radius(23'd0);
        send_pair(24'(LAT_MAX), '0, 24'(-LAT_MAX), '0);
        send_pair('0, '0, '0, 25'(LON_MAX));
        write_radius(23'h7fffff);
        send_pair(24'(LAT_MAX), '0, 24'(-LAT_MAX), '0);
        send_pair('0, 25'(-LON_MAX), '0, 25'(LON_MAX));
        send_pair(24'sd10, 25'sd20, 24'sd30, 25'sd40);
        write_radius(23'd6000000);

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 81 : 0;
            stall_pct     = (ph % 4 == 2) ? 81 : (ph % 4 == 3) ? 24 : 0;
            if (ph % 4 == 3) send_idle_pct = 24;
            for (int n = 0; n < 140; n++) send_random();
            if (ph == 3) write_radius(23'd7000000);
        end

        // Long hold-off with the sender still offering: fill the pipe.
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 200; n++) send_random();
                finish_burst();
            end
        join
        write_radius(23'($urandom_range(7000000, 6000000)));
        for (int n = 0; n < 40; n++) send_random();
        finish_burst();

        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
